>>> hdl/cle_pkg.sv
// Shared types, codes and defaults for the cursor line editor.
package cle_pkg;

  localparam int CAPACITY_DEF = 4096;

  localparam logic [2:0] OP_LEFT   = 3'd0;
  localparam logic [2:0] OP_RIGHT  = 3'd1;
  localparam logic [2:0] OP_BACK   = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_BOUND = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  char_in;
    logic [11:0] position;
  } req_t;

  typedef struct packed {
    logic [12:0] line_length;
    logic [12:0] cursor_index;
    logic [7:0]  char_out;
    logic [1:0]  status;
  } rsp_t;

endpackage

>>> hdl/cle_ram.sv
// Text store: one write port, one read port with registered read data.
module cle_ram #(
  parameter int DEPTH = cle_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/cle_ctrl.sv
// Gap buffer control: cursor and length registers, store addressing, result register.
module cle_ctrl #(
  parameter int CAPACITY = cle_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cle_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cle_pkg::rsp_t rsp,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data
);
  import cle_pkg::*;

  localparam int XW = (CW > 13) ? CW : 13;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t      state;
  logic [CW-1:0] cursor;
  logic [CW-1:0] len;
  logic [2:0]  op_q;
  logic [7:0]  ch_q;
  logic [11:0] pos_q;

  logic          req_acc;
  logic          done;
  logic [CW-1:0] tail;
  logic [CW-1:0] tail_m1;
  logic [CW-1:0] gap;
  logic [XW-1:0] cur_x;
  logic [XW-1:0] len_x;
  logic [XW-1:0] pos_in_x;
  logic [XW-1:0] pos_q_x;
  logic [CW-1:0] rd_addr_c;
  logic [CW-1:0] cursor_next;
  logic [CW-1:0] len_next;
  logic [1:0]    status_c;
  logic [7:0]    char_c;
  logic          wr_want;
  logic [CW-1:0] wr_addr_c;
  logic [7:0]    wr_data_c;
  logic [XW-1:0] len_next_x;
  logic [XW-1:0] cursor_next_x;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign done      = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  assign gap      = CAP_C - len;
  assign tail     = CAP_C - (len - cursor);
  assign tail_m1  = tail - ONE_C;
  assign cur_x    = XW'(cursor);
  assign len_x    = XW'(len);
  assign pos_in_x = XW'(req.position);
  assign pos_q_x  = XW'(pos_q);

  // issue the store read with the incoming word so data is ready next cycle
  always_comb begin
    case (req.operation)
      OP_LEFT:  rd_addr_c = cursor - ONE_C;
      OP_RIGHT: rd_addr_c = tail;
      OP_READ: begin
        if (pos_in_x < cur_x) begin
          rd_addr_c = pos_in_x[CW-1:0];
        end else begin
          rd_addr_c = pos_in_x[CW-1:0] + gap;
        end
      end
      default:  rd_addr_c = '0;
    endcase
  end

  assign rd_en   = req_acc;
  assign rd_addr = rd_addr_c[AW-1:0];

  always_comb begin
    cursor_next = cursor;
    len_next    = len;
    status_c    = ST_DONE;
    char_c      = 8'd0;
    wr_want     = 1'b0;
    wr_addr_c   = cursor;
    wr_data_c   = rd_data;
    case (op_q)
      OP_LEFT: begin
        if (cursor == '0) begin
          status_c = ST_BOUND;
        end else begin
          cursor_next = cursor - ONE_C;
          wr_want     = 1'b1;
          wr_addr_c   = tail_m1;
        end
      end
      OP_RIGHT: begin
        if (cursor >= len) begin
          status_c = ST_BOUND;
        end else begin
          cursor_next = cursor + ONE_C;
          wr_want     = 1'b1;
        end
      end
      OP_BACK: begin
        if (cursor == '0) begin
          status_c = ST_BOUND;
        end else begin
          cursor_next = cursor - ONE_C;
          len_next    = len - ONE_C;
        end
      end
      OP_INSERT: begin
        if (len >= CAP_C) begin
          status_c = ST_FULL;
        end else begin
          cursor_next = cursor + ONE_C;
          len_next    = len + ONE_C;
          wr_want     = 1'b1;
          wr_data_c   = ch_q;
        end
      end
      OP_READ: begin
        if (pos_q_x >= len_x) begin
          status_c = ST_FULL;
        end else begin
          char_c = rd_data;
        end
      end
      default: status_c = ST_BOUND;
    endcase
  end

  // write back once, on the edge that hands the result over
  assign wr_en   = done && wr_want;
  assign wr_addr = wr_addr_c[AW-1:0];
  assign wr_data = wr_data_c;

  assign len_next_x    = XW'(len_next);
  assign cursor_next_x = XW'(cursor_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cursor    <= '0;
      len       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            state <= S_EXEC;
            op_q  <= req.operation;
            ch_q  <= req.char_in;
            pos_q <= req.position;
          end
        end
        S_EXEC: begin
          if (done) begin
            state  <= S_IDLE;
            cursor <= cursor_next;
            len    <= len_next;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (done) begin
        rsp_valid        <= 1'b1;
        rsp.line_length  <= len_next_x[12:0];
        rsp.cursor_index <= cursor_next_x[12:0];
        rsp.char_out     <= char_c;
        rsp.status       <= status_c;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst) cursor <= len)
    else $error("cursor beyond line end");
  a_len_in_cap: assert property (@(posedge clk) disable iff (rst) len <= CAP_C)
    else $error("line longer than store");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst) req_acc |=> !req_acc)
    else $error("word accepted while one is in flight");
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_EXEC))
    else $error("result raised outside execute");
  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_EXEC) && !rd_en)
    else $error("store write outside execute");

endmodule

>>> hdl/cursor_line_editor_unit.sv
// Cursor line editor: a line of text with a cursor kept as a gap buffer in one store.
//
// Channels: req carries one word per operation (left, right, backspace, insert,
// read at position); rsp returns one word per request with the line length,
// cursor, character read and a status code. A word moves when valid is high
// and stall is low at a rising edge.
// The store read is issued on the accepting edge and the write back happens
// on the edge that loads the result, so a new request is not taken before the
// last one's result is loaded; req_stall stays high while the word executes.
// rsp_valid rises on the edge after the accepting edge unless an earlier
// result is still held and stalled on rsp.
// The result sits in an output register; while rsp is stalled the word in
// execution waits in the execute state and no new request is taken.
// Reset (rst, synchronous) empties the line and puts the cursor at 0. The
// store is not cleared; only written entries are ever read back.
module cursor_line_editor_unit #(
  parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cle_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cle_pkg::rsp_t rsp
);
  import cle_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  cle_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  cle_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for cursor_line_editor_unit: directed table, then random edits.
`timescale 1ns / 100ps

module tb;
  import cle_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int TOTAL_ITEMS = 1650;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    req_t        word;
    logic [12:0] reps;
    logic        typed;
    rsp_t        want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // shadow gap buffer
  logic [7:0]  gap_text [0:CAP-1];
  logic [12:0] ed_cursor = '0;
  logic [12:0] ed_len = '0;

  rsp_t      edit_results_q [$];
  plan_row_t plan [$];
  int        mismatches = 0;
  bit        quiet = 1'b0;
  int        stall_left = 0;

  cursor_line_editor_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic rsp_t apply_edit(req_t w);
    rsp_t r;
    int   tail;
    r = '0;
    r.status = ST_DONE;
    tail = CAP - (int'(ed_len) - int'(ed_cursor));
    case (w.operation)
      OP_LEFT: begin
        if (ed_cursor == 0) r.status = ST_BOUND;
        else begin
          ed_cursor = ed_cursor - 13'd1;
          gap_text[12'(tail - 1)] = gap_text[ed_cursor[11:0]];
        end
      end
      OP_RIGHT: begin
        if (ed_cursor >= ed_len) r.status = ST_BOUND;
        else begin
          gap_text[ed_cursor[11:0]] = gap_text[12'(tail)];
          ed_cursor = ed_cursor + 13'd1;
        end
      end
      OP_BACK: begin
        if (ed_cursor == 0) r.status = ST_BOUND;
        else begin
          ed_cursor = ed_cursor - 13'd1;
          ed_len = ed_len - 13'd1;
        end
      end
      OP_INSERT: begin
        if (ed_len >= CAP) r.status = ST_FULL;
        else begin
          gap_text[ed_cursor[11:0]] = w.char_in;
          ed_cursor = ed_cursor + 13'd1;
          ed_len = ed_len + 13'd1;
        end
      end
      OP_READ: begin
        if (w.position >= ed_len) r.status = ST_FULL;
        else if (w.position < ed_cursor) r.char_out = gap_text[w.position];
        else r.char_out = gap_text[12'(int'(w.position) + CAP - int'(ed_len))];
      end
      default: r.status = ST_BOUND;
    endcase
    r.line_length = ed_len;
    r.cursor_index = ed_cursor;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [7:0] ch, input logic [11:0] pos,
                         input int reps, input bit typed, input logic [12:0] len,
                         input logic [12:0] cur, input logic [7:0] c, input logic [1:0] st);
    plan_row_t row;
    row.word = '{operation: op, char_in: ch, position: pos};
    row.reps = 13'(reps);
    row.typed = typed;
    row.want = '{line_length: len, cursor_index: cur, char_out: c, status: st};
    plan.push_back(row);
  endtask

  // Send one word, then record what it should produce.
  task automatic issue(input req_t w, input bit typed, input rsp_t want);
    int   gap;
    rsp_t got;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (req_stall);
    got = apply_edit(w);
    edit_results_q.push_back(typed ? want : got);
  endtask

  // Receive side: check each word against the oldest expectation, then pick the stall.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (edit_results_q.size() == 0) begin
        $display("%0t: unexpected result len=%0d cur=%0d char=%h status=%0d", $time,
                 rsp.line_length, rsp.cursor_index, rsp.char_out, rsp.status);
        mismatches++;
      end else begin
        want = edit_results_q.pop_front();
        if (rsp.line_length !== want.line_length) begin
          $display("%0t: line_length expected %0d got %0d", $time,
                   want.line_length, rsp.line_length);
          mismatches++;
        end
        if (rsp.cursor_index !== want.cursor_index) begin
          $display("%0t: cursor_index expected %0d got %0d", $time,
                   want.cursor_index, rsp.cursor_index);
          mismatches++;
        end
        if (rsp.char_out !== want.char_out) begin
          $display("%0t: char_out expected %h got %h", $time, want.char_out, rsp.char_out);
          mismatches++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
          mismatches++;
        end
      end
    end
    if (stall_left == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  initial begin
    req_t       w;
    rsp_t       none;
    int         done_cnt;
    int         roll;
    int         top;

    none = '0;
    done_cnt = 0;
    // empty line: every move, read and spare code is refused, then a short line is typed, read and edited
    add_row(OP_LEFT,     8'h00, 12'd0,   1, 1, 0, 0, 8'h00, ST_BOUND);
    add_row(OP_RIGHT,    8'hFF, 12'hFFF, 1, 1, 0, 0, 8'h00, ST_BOUND);
    add_row(OP_BACK,     8'h00, 12'd0,   1, 1, 0, 0, 8'h00, ST_BOUND);
    add_row(OP_READ,     8'h00, 12'd0,   1, 1, 0, 0, 8'h00, ST_FULL);
    add_row(OP_SPARE_LO, 8'h00, 12'd0,   1, 1, 0, 0, 8'h00, ST_BOUND);
    add_row(OP_SPARE_HI, 8'hFF, 12'hFFF, 1, 1, 0, 0, 8'h00, ST_BOUND);
    add_row(OP_INSERT,   "L",   12'd0,   1, 1, 1, 1, 8'h00, ST_DONE);
    add_row(OP_INSERT,   "D",   12'd0,   1, 1, 2, 2, 8'h00, ST_DONE);
    add_row(OP_INSERT,   "B",   12'd0,   1, 1, 3, 3, 8'h00, ST_DONE);
    add_row(OP_READ,     8'h00, 12'd0,   1, 1, 3, 3, "L",   ST_DONE);
    add_row(OP_READ,     8'h00, 12'd2,   1, 1, 3, 3, "B",   ST_DONE);
    add_row(OP_READ,     8'h00, 12'd3,   1, 1, 3, 3, 8'h00, ST_FULL);
    add_row(OP_LEFT,     8'h00, 12'd0,   1, 0, 0, 0, 8'h00, ST_DONE);
    add_row(OP_LEFT,     8'h00, 12'd0,   1, 0, 0, 0, 8'h00, ST_DONE);
    add_row(OP_INSERT,   8'hFF, 12'd0,   1, 0, 0, 0, 8'h00, ST_DONE);
    add_row(OP_READ,     8'h00, 12'hFFF, 1, 1, 4, 2, 8'h00, ST_FULL);
    add_row(OP_READ,     8'h00, 12'd1,   1, 0, 0, 0, 8'h00, ST_DONE);
    add_row(OP_RIGHT,    8'h00, 12'd0,   3, 0, 0, 0, 8'h00, ST_DONE);
    add_row(OP_BACK,     8'h00, 12'd0,   1, 0, 0, 0, 8'h00, ST_DONE);
    // grow a long line, sweep the cursor across it, then cut it back
    add_row(OP_INSERT,   8'h00, 12'd0,   300, 0, 0, 0, 8'h00, ST_DONE);
    add_row(OP_READ,     8'h00, 12'hFFF, 1, 0, 0, 0, 8'h00, ST_DONE);
    add_row(OP_LEFT,     8'h00, 12'd0,   200, 0, 0, 0, 8'h00, ST_DONE);
    add_row(OP_INSERT,   "D",   12'd0,   1, 0, 0, 0, 8'h00, ST_DONE);
    add_row(OP_RIGHT,    8'h00, 12'd0,   220, 0, 0, 0, 8'h00, ST_DONE);
    add_row(OP_BACK,     8'h00, 12'd0,   250, 0, 0, 0, 8'h00, ST_DONE);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < plan[i].reps; k++) begin
        w = plan[i].word;
        // vary content on repeated rows
        if (plan[i].reps > 1) w.char_in = 8'($urandom);
        issue(w, plan[i].typed, plan[i].want);
        done_cnt++;
      end
    end

    while (done_cnt < TOTAL_ITEMS) begin
      if (done_cnt % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      w.char_in = 8'($urandom);
      w.position = 12'($urandom);
      if (roll == 99 && ed_len != 0) begin
        // print the whole line as a run of reads
        top = int'(ed_len);
        for (int p = 0; p < top; p++) begin
          w.operation = OP_READ;
          w.position = 12'(p);
          issue(w, 1'b0, none);
          done_cnt++;
        end
      end else begin
        if (roll < 34) w.operation = OP_INSERT;
        else if (roll < 50) w.operation = OP_LEFT;
        else if (roll < 64) w.operation = OP_RIGHT;
        else if (roll < 78) w.operation = OP_BACK;
        else if (roll < 96) w.operation = OP_READ;
        else w.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        if (w.operation == OP_READ && $urandom_range(0, 4) != 0)
          w.position = 12'($urandom_range(0, ed_len > CAP - 1 ? CAP - 1 : ed_len));
        issue(w, 1'b0, none);
        done_cnt++;
      end
    end
    req_valid <= 1'b0;

    while (edit_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
